/* sv/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table: opcodes,
// status codes, slot tags, slot row layout, transaction structs and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 9;
  localparam int HASH_BITS     = 16;

  localparam logic [31:0] KNUTH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_UPDATE = 2'd1,
    WR_DELETE = 2'd2,
    WR_INSERT = 2'd3
  } wr_kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lpht_req_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] value_out;
    logic [COUNT_BITS-1:0] entry_count;
  } lpht_rsp_t;

  typedef struct packed {
    tag_t                  tag;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_row_t;

  typedef struct packed {
    logic     load;
    logic     probe_init;
    logic     advance;
    logic     sweep;
    wr_kind_t wr_kind;
    logic     finish;
    status_t  fin_status;
    logic     fin_value;
    logic     count_clear;
  } lpht_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic sweep_last;
    logic hit;
    logic stop;
    logic free_avail;
  } lpht_stat_t;

endpackage

/* sv/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key/value table with open addressing, multiplicative hashing and linear
// probing, with tombstones for deleted slots.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; req carries
//   opcode (lookup, insert or update, delete, clear all), key and value.
//   Exactly one result per transaction appears on rsp for one cycle with
//   done high: status, value_out and the live entry count after the
//   transaction. The receiver cannot stall; results are never held.
//   Steps: load and multiply, then reduce the hash to a home slot (with a
//   registered quotient step when SLOTS is not a power of two), then per
//   probed slot a RAM read, then compare and write, then the registered
//   done strobe. Busy is low again in the cycle of done, so a new
//   transaction may be started there.
//   Clear all sweeps the slot RAM, one slot per cycle.
//   After reset the same sweep runs with busy high.
//   One transaction is in flight at a time; throughput is set by the
//   probe loop over the simple dual port slot RAM.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lpht_pkg::lpht_req_t req,
  output logic                done,
  output lpht_pkg::lpht_rsp_t rsp
);

  import lpht_pkg::*;

  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  lpht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .done (done),
    .rsp  (rsp)
  );

endmodule

/* sv/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: sequences the initial clearing pass, hashing, the probe loop,
// slot writes and result issue for each transaction.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lpht_pkg::opcode_t   opcode,
  input  lpht_pkg::lpht_stat_t stat,
  output logic                busy,
  output lpht_pkg::lpht_cmd_t cmd
);

  import lpht_pkg::*;

  state_t  state;
  state_t  state_next;
  opcode_t op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op <= opcode;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd.load        = 1'b0;
    cmd.probe_init  = 1'b0;
    cmd.advance     = 1'b0;
    cmd.sweep       = 1'b0;
    cmd.wr_kind     = WR_NONE;
    cmd.finish      = 1'b0;
    cmd.fin_status  = STATUS_OK;
    cmd.fin_value   = 1'b0;
    cmd.count_clear = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (opcode == OP_CLEAR) ? ST_CLEAR : ST_HASH;
        end
      end
      ST_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.hit) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
          case (op)
            OP_LOOKUP: cmd.fin_value = 1'b1;
            OP_INSERT: cmd.wr_kind = WR_UPDATE;
            OP_DELETE: begin
              cmd.wr_kind   = WR_DELETE;
              cmd.fin_value = 1'b1;
            end
            default: cmd.fin_value = 1'b0;
          endcase
        end else if (stat.stop) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
          if (op == OP_INSERT) begin
            if (stat.free_avail) begin
              cmd.wr_kind = WR_INSERT;
            end else begin
              cmd.fin_status = STATUS_FULL;
            end
          end else begin
            cmd.fin_status = STATUS_NOT_FOUND;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.finish      = 1'b1;
          cmd.count_clear = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

/* sv/lpht_datapath.sv */
// ----------------------------------------------------------------------------
// lpht_datapath
// Datapath: operand registers, multiplicative hash with home slot
// reduction, probe index and counters, slot RAM, entry count and the
// registered result.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lpht_pkg::lpht_req_t  req,
  input  lpht_pkg::lpht_cmd_t  cmd,
  output lpht_pkg::lpht_stat_t stat,
  output logic                 done,
  output lpht_pkg::lpht_rsp_t  rsp
);

  import lpht_pkg::*;

  localparam int  IDX_W = $clog2(SLOTS);
  localparam int  CNT_W = $clog2(SLOTS + 1);
  localparam bit  POW2  = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  logic [KEY_BITS-1:0]      op_key;
  logic [VALUE_BITS-1:0]    op_value;
  logic [63:0]              mul_full;
  logic [31:0]              prod;
  logic [HASH_BITS-1:0]     hval;
  logic                     hash_pending;
  logic                     hash_stage;
  logic [HASH_BITS+31:0]    recip_prod;
  logic [HASH_BITS-1:0]     quo;
  logic [HASH_BITS:0]       quo_mul;
  logic [HASH_BITS:0]       rem;
  logic [IDX_W-1:0]         home;

  logic [IDX_W-1:0]         idx;
  logic [CNT_W-1:0]         n;
  logic                     free_valid;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         sweep_addr;
  logic                     sweep_last;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  slot_row_t                ram_wdata;
  slot_row_t                row;

  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CNT_W+COUNT_BITS-1:0] cnt_ext;

  // hash
  assign mul_full = req.key * KNUTH_MULT;
  assign hval     = prod[31:16];

  // home slot by reciprocal multiplication, quotient registered
  assign recip_prod = hval * RECIP;
  assign quo_mul    = {1'b0, quo} * (HASH_BITS+1)'(SLOTS);
  assign rem        = {1'b0, hval} - quo_mul;

  assign home = POW2 ? hval[IDX_W-1:0] : rem[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_key   <= req.key;
      op_value <= req.value;
      prod     <= mul_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    quo <= recip_prod[HASH_BITS+31:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_pending <= 1'b0;
      hash_stage   <= 1'b0;
    end else if (cmd.load) begin
      hash_pending <= 1'b1;
      hash_stage   <= 1'b0;
    end else if (cmd.probe_init) begin
      hash_pending <= 1'b0;
    end else if (hash_pending) begin
      hash_stage <= 1'b1;
    end
  end

  // probe walk
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx        <= home;
      n          <= '0;
      free_valid <= 1'b0;
    end else if (cmd.advance) begin
      idx <= (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + IDX_W'(1);
      n   <= n + CNT_W'(1);
      if (!free_valid && row.tag != TAG_USED) begin
        free_valid <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

  // clearing sweep
  assign sweep_last = (sweep_addr == IDX_W'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + IDX_W'(1);
    end
  end

  // slot writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = row;
    if (cmd.sweep) begin
      ram_we          = 1'b1;
      ram_waddr       = sweep_addr;
      ram_wdata.tag   = TAG_EMPTY;
      ram_wdata.key   = '0;
      ram_wdata.value = '0;
    end else begin
      case (cmd.wr_kind)
        WR_UPDATE: begin
          ram_we          = 1'b1;
          ram_wdata.value = op_value;
        end
        WR_DELETE: begin
          ram_we        = 1'b1;
          ram_wdata.tag = TAG_GONE;
        end
        WR_INSERT: begin
          ram_we          = 1'b1;
          ram_waddr       = free_valid ? free_idx : idx;
          ram_wdata.tag   = TAG_USED;
          ram_wdata.key   = op_key;
          ram_wdata.value = op_value;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  lpht_ram #(
    .WIDTH ($bits(slot_row_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (row)
  );

  // status to controller
  assign stat.hash_done  = hash_pending && (POW2 || hash_stage);
  assign stat.sweep_last = sweep_last;
  assign stat.hit        = (row.tag == TAG_USED) && (row.key == op_key);
  assign stat.stop       = (row.tag == TAG_EMPTY) || (n == CNT_W'(SLOTS - 1));
  assign stat.free_avail = free_valid || (row.tag != TAG_USED);

  // live entry count
  always_comb begin
    cnt_next = cnt;
    if (cmd.finish && cmd.count_clear) begin
      cnt_next = '0;
    end else if (cmd.wr_kind == WR_INSERT) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.wr_kind == WR_DELETE && cnt != '0) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  assign cnt_ext = {{COUNT_BITS{1'b0}}, cnt_next};

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status      <= cmd.fin_status;
      rsp.value_out   <= cmd.fin_value ? row.value : '0;
      rsp.entry_count <= cnt_ext[COUNT_BITS-1:0];
    end
  end

endmodule
